FILE: rtl/ddft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddft_pkg;

    localparam int POINTS_DEF  = 64;
    localparam int SAMPLE_W    = 16;
    localparam int BIN_W       = 22;
    localparam int FRAC_W      = 15;
    localparam int IN_TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * BIN_W + 7) / 8) * 8;

    // pi/2 and one in Q30
    localparam int HALF_PI_Q30 = 1686629713;
    localparam int Q30_ONE     = 1073741824;

    typedef struct packed {
        logic load_we;   // store the accepted sample word
        logic issue;     // one multiply-accumulate step enters the datapath
        logic first;     // first step of a bin
        logic last;      // last step of a bin
        logic bin_last;  // bin under work is the final one of the run
    } ddft_cmd_t;

    typedef struct packed {
        logic push;      // finished bin moves into the output register
    } ddft_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ddft_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ddft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/ddft_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ddft_ctrl
    import ddft_pkg::*;
#(
    parameter int POINTS = POINTS_DEF,
    localparam int IDX_W = $clog2(POINTS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ddft_stat_t       stat,
    output ddft_cmd_t             cmd,
    output logic      [IDX_W-1:0] addr,
    output logic      [IDX_W-1:0] k_step
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN
    } state_t;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] k_reg, k_next;

    always_comb
    begin
        in_ready     = (state_reg == ST_LOAD);
        cmd.load_we  = in_ready && in_valid;
        cmd.issue    = (state_reg == ST_MAC);
        cmd.first    = (cnt_reg == '0);
        cmd.last     = (cnt_reg == IDX_LAST);
        cmd.bin_last = (k_reg == IDX_LAST);
        addr         = cnt_reg;
        k_step       = k_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (cnt_reg == IDX_LAST)
                    begin
                        cnt_next   = '0;
                        k_next     = '0;
                        state_next = ST_MAC;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_MAC:
            begin
                if (cnt_reg == IDX_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // wait for the bin to leave the rounding pipe
                if (stat.push)
                begin
                    if (k_reg == IDX_LAST)
                    begin
                        k_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    a_no_load_during_mac: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.issue && cmd.load_we))
        else $error("sample write during accumulation");

    a_push_only_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        stat.push |-> (state_reg == ST_DRAIN))
        else $error("bin pushed outside drain");

    a_last_step_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && cmd.last) |=> (state_reg == ST_DRAIN))
        else $error("accumulation did not stop after last step");

endmodule

`default_nettype wire

FILE: rtl/ddft_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ddft_dp
    import ddft_pkg::*;
#(
    parameter int POINTS = POINTS_DEF,
    localparam int IDX_W = $clog2(POINTS)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_data,
    input  wire logic signed [SAMPLE_W-1:0] in_real,
    input  wire logic signed [SAMPLE_W-1:0] in_imag,
    input  wire ddft_cmd_t                  cmd,
    input  wire logic        [IDX_W-1:0]    addr,
    input  wire logic        [IDX_W-1:0]    k_step,
    output ddft_stat_t                      stat,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed      [BIN_W-1:0]    bin_real,
    output logic signed      [BIN_W-1:0]    bin_imag,
    output logic                            last_bin
);

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int ACC_W  = SUM_W + IDX_W;
    localparam int T_W    = ACC_W - FRAC_W;
    localparam int MAG_W  = T_W - 1;
    localparam int EXT_W  = (T_W > BIN_W) ? T_W : BIN_W;

    localparam logic signed [ACC_W-1:0] OFF_FWD = ACC_W'(64'sd1 <<< (FRAC_W - 1));
    localparam logic signed [ACC_W-1:0] OFF_INV = ACC_W'(64'sd1 <<< (FRAC_W - 1)) * POINTS;

    // floor(v / POINTS) as (v * RECIP) >> 32 for the magnitudes seen here
    localparam logic [63:0] RECIP64 = ((64'd1 << 32) + POINTS - 1) / POINTS;
    localparam logic [31:0] RECIP   = RECIP64[31:0];

    localparam logic signed [EXT_W-1:0] LIM_HI = EXT_W'((64'sd1 <<< (BIN_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] LIM_LO = -LIM_HI - 1;

    function automatic logic signed [SAMPLE_W-1:0] q30_to_q15(input longint v);
        longint vc;
        longint rq;
        vc = (v < 0) ? 0 : v;
        rq = (vc + 16384) >>> 15;
        if (rq > 32767)
        begin
            rq = 32767;
        end
        return rq[SAMPLE_W-1:0];
    endfunction

    // {sin, cos} in Q1.15 for phase m of POINTS
    function automatic logic [PROD_W-1:0] tw_calc(input int m);
        longint u;
        longint quad;
        longint r;
        longint x;
        longint term;
        longint s;
        longint c;
        logic swap;
        logic signed [SAMPLE_W-1:0] s15;
        logic signed [SAMPLE_W-1:0] c15;
        logic signed [SAMPLE_W-1:0] t15;
        logic signed [SAMPLE_W-1:0] co;
        logic signed [SAMPLE_W-1:0] si;
        u    = 4 * m;
        quad = (u / POINTS) % 4;
        r    = u % POINTS;
        swap = (2 * r > POINTS);
        if (swap)
        begin
            r = POINTS - r;
        end
        x = (longint'(HALF_PI_Q30) * r) / POINTS;

        term = x;
        s    = x;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 6;    s = s - term;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 20;   s = s + term;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 42;   s = s - term;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 72;   s = s + term;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 110;  s = s - term;

        term = Q30_ONE;
        c    = Q30_ONE;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 2;    c = c - term;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 12;   c = c + term;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 30;   c = c - term;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 56;   c = c + term;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 90;   c = c - term;
        term = (term * x) >>> 30;  term = (term * x) >>> 30;  term = term / 132;  c = c + term;

        s15 = q30_to_q15(s);
        c15 = q30_to_q15(c);
        if (swap)
        begin
            t15 = s15;
            s15 = c15;
            c15 = t15;
        end
        case (quad)
            0:
            begin
                co = c15;
                si = s15;
            end
            1:
            begin
                co = -s15;
                si = c15;
            end
            2:
            begin
                co = -c15;
                si = -s15;
            end
            default:
            begin
                co = s15;
                si = -c15;
            end
        endcase
        return {si, co};
    endfunction

    function automatic logic signed [BIN_W-1:0] clip(input logic signed [T_W-1:0] v);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e > LIM_HI)
        begin
            e = LIM_HI;
        end
        else if (e < LIM_LO)
        begin
            e = LIM_LO;
        end
        return e[BIN_W-1:0];
    endfunction

    // twiddle table, built at elaboration
    logic [PROD_W-1:0] tw_rom [POINTS];

    for (genvar g = 0; g < POINTS; g++)
    begin : g_tw
        assign tw_rom[g] = tw_calc(g);
    end

    logic direction_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            direction_reg <= cfg_data;
        end
    end

    // sample store, real part in the low half
    logic [PROD_W-1:0] ram_rdata;

    ddft_ram #(
        .WIDTH (PROD_W),
        .DEPTH (POINTS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_we),
        .addr  (addr),
        .wdata ({in_imag, in_real}),
        .rdata (ram_rdata)
    );

    // phase (k * j) mod POINTS, stepped by k
    logic [IDX_W-1:0] phase_reg, phase_next;
    logic [IDX_W-1:0] idx;
    logic [IDX_W:0]   phase_sum;

    always_comb
    begin
        idx       = cmd.first ? '0 : phase_reg;
        phase_sum = {1'b0, idx} + {1'b0, k_step};
        if (phase_sum >= (IDX_W + 1)'(POINTS))
        begin
            phase_next = IDX_W'(phase_sum - (IDX_W + 1)'(POINTS));
        end
        else
        begin
            phase_next = phase_sum[IDX_W-1:0];
        end
    end

    logic [PROD_W-1:0] tw_reg;
    logic              v1_reg, first1_reg, last1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            last1_reg  <= 1'b0;
        end
        else
        begin
            v1_reg     <= cmd.issue;
            first1_reg <= cmd.first;
            last1_reg  <= cmd.last;
            if (cmd.issue)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            tw_reg <= tw_rom[idx];
        end
    end

    // products
    logic signed [SAMPLE_W-1:0] xr, xi, tc, ts;
    logic signed [PROD_W-1:0]   p_rc_reg, p_is_reg, p_ic_reg, p_rs_reg;
    logic                       v2_reg, first2_reg, last2_reg;

    assign xr = signed'(ram_rdata[SAMPLE_W-1:0]);
    assign xi = signed'(ram_rdata[PROD_W-1:SAMPLE_W]);
    assign tc = signed'(tw_reg[SAMPLE_W-1:0]);
    assign ts = signed'(tw_reg[PROD_W-1:SAMPLE_W]);

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            p_rc_reg <= xr * tc;
            p_is_reg <= xi * ts;
            p_ic_reg <= xi * tc;
            p_rs_reg <= xr * ts;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg     <= 1'b0;
            first2_reg <= 1'b0;
            last2_reg  <= 1'b0;
        end
        else
        begin
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
        end
    end

    // accumulate, conjugate kernel for forward
    logic signed [SUM_W-1:0] sum_r, sum_i;
    logic signed [ACC_W-1:0] acc_r_reg, acc_i_reg;
    logic                    done3_reg;

    always_comb
    begin
        if (direction_reg)
        begin
            sum_r = p_rc_reg - p_is_reg;
            sum_i = p_rs_reg + p_ic_reg;
        end
        else
        begin
            sum_r = p_rc_reg + p_is_reg;
            sum_i = p_ic_reg - p_rs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            acc_r_reg <= first2_reg ? ACC_W'(sum_r) : acc_r_reg + ACC_W'(sum_r);
            acc_i_reg <= first2_reg ? ACC_W'(sum_i) : acc_i_reg + ACC_W'(sum_i);
        end
    end

    // rounding: add half, drop fraction, then split sign and magnitude for the divide
    logic signed [ACC_W-1:0] rnd_r, rnd_i;
    logic signed [T_W-1:0]   t_r_reg, t_i_reg;
    logic                    neg_r_reg, neg_i_reg;
    logic [MAG_W-1:0]        mag_r_reg, mag_i_reg;
    logic                    v4_reg, v5_reg;
    logic [MAG_W+31:0]       prod_r_reg, prod_i_reg;

    assign rnd_r = acc_r_reg + (direction_reg ? OFF_INV : OFF_FWD);
    assign rnd_i = acc_i_reg + (direction_reg ? OFF_INV : OFF_FWD);

    always_ff @(posedge clk)
    begin
        if (done3_reg)
        begin
            t_r_reg   <= signed'(rnd_r[ACC_W-1:FRAC_W]);
            t_i_reg   <= signed'(rnd_i[ACC_W-1:FRAC_W]);
            neg_r_reg <= rnd_r[ACC_W-1];
            neg_i_reg <= rnd_i[ACC_W-1];
            // negative v: floor(v/n) = -floor((-v-1)/n) - 1, and -v-1 is ~v
            mag_r_reg <= rnd_r[ACC_W-1] ? ~rnd_r[ACC_W-2:FRAC_W] : rnd_r[ACC_W-2:FRAC_W];
            mag_i_reg <= rnd_i[ACC_W-1] ? ~rnd_i[ACC_W-2:FRAC_W] : rnd_i[ACC_W-2:FRAC_W];
        end
        if (v4_reg)
        begin
            prod_r_reg <= mag_r_reg * RECIP;
            prod_i_reg <= mag_i_reg * RECIP;
        end
    end

    logic [MAG_W-1:0]      q_r, q_i;
    logic signed [T_W-1:0] qs_r, qs_i;
    logic signed [BIN_W-1:0] res_r_reg, res_i_reg;
    logic                  res_valid_reg;
    logic                  push;
    logic                  out_valid_reg;
    logic                  last_bin_reg;
    logic signed [BIN_W-1:0] bin_real_reg, bin_imag_reg;

    assign q_r  = prod_r_reg[MAG_W+31:32];
    assign q_i  = prod_i_reg[MAG_W+31:32];
    assign qs_r = neg_r_reg ? signed'(~{1'b0, q_r}) : signed'({1'b0, q_r});
    assign qs_i = neg_i_reg ? signed'(~{1'b0, q_i}) : signed'({1'b0, q_i});

    always_ff @(posedge clk)
    begin
        if (v5_reg)
        begin
            res_r_reg <= clip(direction_reg ? qs_r : t_r_reg);
            res_i_reg <= clip(direction_reg ? qs_i : t_i_reg);
        end
    end

    assign push      = res_valid_reg && (!out_valid_reg || out_ready);
    assign stat.push = push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done3_reg     <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done3_reg <= v2_reg && last2_reg;
            v4_reg    <= done3_reg;
            v5_reg    <= v4_reg;
            if (v5_reg)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                res_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bin_real_reg <= res_r_reg;
            bin_imag_reg <= res_i_reg;
            last_bin_reg <= cmd.bin_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_real  = bin_real_reg;
    assign bin_imag  = bin_imag_reg;
    assign last_bin  = last_bin_reg;

    a_push_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("pushed bin not shown at output");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !push) |=> res_valid_reg)
        else $error("finished bin dropped before push");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> !res_valid_reg)
        else $error("new bin overwrites an unpushed one");

endmodule

`default_nettype wire

FILE: rtl/direct_dft_forward_inverse.sv
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: sample_real, sample_imag
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: bin_real, bin_imag; tlast: last_bin
// cfg       in   cfg_valid / cfg_ready           cfg_data: direction
//
// a run loads POINTS sample words, one per cycle, then computes the bins in order
// each bin is accumulated on the complex multiply-accumulate unit, then passes
// through the rounding and (inverse only) divide-by-POINTS pipe into the output register
// one finished bin waits in the output register while the next one is accumulated;
// a stall longer than that stops the accumulator
// reset clears control and direction; the sample store needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module direct_dft_forward_inverse
    import ddft_pkg::*;
#(
    parameter int POINTS = POINTS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample_real, sample_imag
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // bin_real, bin_imag, zero pad
    output logic                        m_axis_tlast,   // last_bin
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [0:0]             cfg_data        // direction
);

    localparam int IDX_W = $clog2(POINTS);

    ddft_cmd_t               cmd;
    ddft_stat_t              stat;
    logic [IDX_W-1:0]        addr;
    logic [IDX_W-1:0]        k_step;
    logic signed [BIN_W-1:0] bin_real;
    logic signed [BIN_W-1:0] bin_imag;

    assign cfg_ready = 1'b1;

    ddft_ctrl #(
        .POINTS (POINTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd),
        .addr     (addr),
        .k_step   (k_step)
    );

    ddft_dp #(
        .POINTS (POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data[0]),
        .in_real   (signed'(s_axis_tdata[SAMPLE_W-1:0])),
        .in_imag   (signed'(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W])),
        .cmd       (cmd),
        .addr      (addr),
        .k_step    (k_step),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .bin_real  (bin_real),
        .bin_imag  (bin_imag),
        .last_bin  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 2 * BIN_W){1'b0}}, bin_imag, bin_real};

endmodule

`default_nettype wire

FILE: bench/direct_dft_forward_inverse_test.sv
`timescale 1ns / 1ps

module direct_dft_forward_inverse_test;

    localparam int N          = ddft_pkg::POINTS_DEF;
    localparam int IW         = ddft_pkg::IN_TDATA_W;
    localparam int OW         = ddft_pkg::OUT_TDATA_W;
    localparam int SW         = ddft_pkg::SAMPLE_W;
    localparam int BW         = ddft_pkg::BIN_W;
    localparam int FWD_SHIFT  = ddft_pkg::FRAC_W;
    localparam int INV_SHIFT  = ddft_pkg::FRAC_W + $clog2(N);
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint UNIT_Q30         = 64'sd1 <<< 30;
    localparam longint BIN_HI   = (64'sd1 <<< (BW - 1)) - 1;
    localparam longint BIN_LO   = -(64'sd1 <<< (BW - 1));
    localparam int SETTLE       = N + 6;
    localparam int LONG_HOLD    = 900;
    localparam int QUIET_LIMIT  = 8000;

    typedef enum bit {
        DIR_FORWARD = 1'b0,
        DIR_INVERSE = 1'b1
    } dir_e;

    typedef enum int {
        FILL_FULL    = 0,
        FILL_SMALL   = 1,
        FILL_CORNERS = 2
    } fill_e;

    typedef struct {
        logic signed [BW-1:0] re;
        logic signed [BW-1:0] im;
        logic                 last;
    } bin_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [IW-1:0] s_axis_tdata = '0;     // sample_real, sample_imag
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [OW-1:0] m_axis_tdata;          // bin_real, bin_imag, zero pad
    logic          m_axis_tlast;          // last_bin
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [0:0]    cfg_data = 1'b0;       // direction

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   mismatches = 0;

    int   cos_tab[N];
    int   sin_tab[N];
    logic signed [SW-1:0] load_re[N];
    logic signed [SW-1:0] load_im[N];
    int   load_count = 0;
    dir_e dir_now = DIR_FORWARD;
    bin_t expected_bins[$];

    direct_dft_forward_inverse #(
        .POINTS(N)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // Q30 to Q1.15, negatives floored at zero
    function automatic int q15_of(longint v);
        longint r;
        if (v < 0)
        begin
            v = 0;
        end
        r = (v + 64'sd16384) >>> 15;
        return (r > 32767) ? 32767 : int'(r);
    endfunction

    // twiddle for phase m: taylor series on the reduced angle, then quadrant symmetry
    function automatic void twiddle_at(input int m, output int co, output int si);
        int     u;
        int     quad;
        int     r;
        int     n;
        bit     swap;
        longint x;
        longint term;
        longint s;
        longint c;
        int     s15;
        int     c15;
        int     t;
        u    = 4 * m;
        quad = (u / N) & 3;
        r    = u % N;
        swap = (2 * r > N);
        if (swap)
        begin
            r = N - r;
        end
        x = (QUARTER_TURN_Q30 * r) / N;
        term = x;
        s    = x;
        for (n = 1; n <= 5; n++)
        begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / ((2 * n) * (2 * n + 1));
            s = (n & 1) ? s - term : s + term;
        end
        term = UNIT_Q30;
        c    = UNIT_Q30;
        for (n = 1; n <= 6; n++)
        begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / ((2 * n - 1) * (2 * n));
            c = (n & 1) ? c - term : c + term;
        end
        s15 = q15_of(s);
        c15 = q15_of(c);
        if (swap)
        begin
            t   = s15;
            s15 = c15;
            c15 = t;
        end
        case (quad)
            0: begin co = c15;  si = s15;  end
            1: begin co = -s15; si = c15;  end
            2: begin co = -c15; si = -s15; end
            default: begin co = s15; si = -c15; end
        endcase
    endfunction

    function automatic longint clip_bin(longint v);
        if (v > BIN_HI)
        begin
            return BIN_HI;
        end
        if (v < BIN_LO)
        begin
            return BIN_LO;
        end
        return v;
    endfunction

    // full direct transform of the loaded set, one expected bin per k
    function automatic void predict_spectrum();
        longint acc_r;
        longint acc_i;
        longint xr;
        longint xi;
        longint c;
        longint s;
        int     k;
        int     j;
        int     m;
        bin_t   b;
        for (k = 0; k < N; k++)
        begin
            acc_r = 0;
            acc_i = 0;
            for (j = 0; j < N; j++)
            begin
                m  = (k * j) % N;
                c  = cos_tab[m];
                s  = sin_tab[m];
                xr = load_re[j];
                xi = load_im[j];
                if (dir_now == DIR_FORWARD)
                begin
                    acc_r += xr * c + xi * s;
                    acc_i += xi * c - xr * s;
                end
                else
                begin
                    acc_r += xr * c - xi * s;
                    acc_i += xr * s + xi * c;
                end
            end
            if (dir_now == DIR_FORWARD)
            begin
                acc_r = (acc_r + (64'sd1 <<< (FWD_SHIFT - 1))) >>> FWD_SHIFT;
                acc_i = (acc_i + (64'sd1 <<< (FWD_SHIFT - 1))) >>> FWD_SHIFT;
            end
            else
            begin
                acc_r = (acc_r + (64'sd1 <<< (INV_SHIFT - 1))) >>> INV_SHIFT;
                acc_i = (acc_i + (64'sd1 <<< (INV_SHIFT - 1))) >>> INV_SHIFT;
            end
            acc_r  = clip_bin(acc_r);
            acc_i  = clip_bin(acc_i);
            b.re   = acc_r[BW-1:0];
            b.im   = acc_i[BW-1:0];
            b.last = (k == N - 1);
            expected_bins.push_back(b);
        end
    endfunction

    function automatic logic [SW-1:0] pick_sample(fill_e style);
        case (style)
            FILL_SMALL:
                return SW'(int'($urandom_range(0, 511)) - 256);
            FILL_CORNERS:
                case ($urandom_range(0, 7))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    4: return 16'h0001;
                    5: return 16'h8001;
                    default: return SW'($urandom_range(0, 65535));
                endcase
            default:
                return SW'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sample(input logic [SW-1:0] re, input logic [SW-1:0] im);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        do
            @(posedge clk);
        while (!s_axis_tready);
        load_re[load_count] = re;
        load_im[load_count] = im;
        load_count++;
        if (load_count == N)
        begin
            predict_spectrum();
            load_count = 0;
        end
    endtask

    // sender goes quiet until every bin is back, then the pipe gets time to empty
    task automatic wait_for_spectrum_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_bins.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_direction(input dir_e dir);
        cfg_valid <= 1'b1;
        cfg_data  <= dir;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dir_now = dir;
    endtask

    task automatic send_random_frame(input fill_e style);
        int j;
        for (j = 0; j < N; j++)
        begin
            send_sample(pick_sample(style), pick_sample(style));
        end
    endtask

    // corner values at the head of the set, same set through both directions
    task automatic test_extremes();
        logic [SW-1:0] corner_re[8];
        logic [SW-1:0] corner_im[8];
        logic [SW-1:0] set_re[N];
        logic [SW-1:0] set_im[N];
        int j;
        corner_re = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                      16'h0001, 16'h7FFF, 16'h8000, 16'h5555};
        corner_im = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                      16'h0001, 16'h8000, 16'h7FFF, 16'hAAAA};
        for (j = 0; j < N; j++)
        begin
            set_re[j] = (j < 8) ? corner_re[j] : pick_sample(FILL_FULL);
            set_im[j] = (j < 8) ? corner_im[j] : pick_sample(FILL_FULL);
        end
        write_direction(DIR_FORWARD);
        for (j = 0; j < N; j++)
        begin
            send_sample(set_re[j], set_im[j]);
        end
        wait_for_spectrum_drain();
        write_direction(DIR_INVERSE);
        for (j = 0; j < N; j++)
        begin
            send_sample(set_re[j], set_im[j]);
        end
        wait_for_spectrum_drain();
    endtask

    // full-scale samples aligned with the bin 1 kernel push that bin past the output range
    task automatic test_clipping();
        int j;
        write_direction(DIR_FORWARD);
        for (j = 0; j < N; j++)
        begin
            send_sample((cos_tab[j] >= 0) ? 16'h7FFF : 16'h8001,
                        (sin_tab[j] >= 0) ? 16'h7FFF : 16'h8001);
        end
        wait_for_spectrum_drain();
        for (j = 0; j < N; j++)
        begin
            send_sample((cos_tab[j] >= 0) ? 16'h8000 : 16'h7FFF,
                        (sin_tab[j] >= 0) ? 16'h8000 : 16'h7FFF);
        end
        wait_for_spectrum_drain();
    endtask

    task automatic test_random_frames(input int count);
        int f;
        for (f = 0; f < count; f++)
        begin
            write_direction(dir_e'($urandom_range(0, 1)));
            send_random_frame(fill_e'($urandom_range(0, 2)));
            wait_for_spectrum_drain();
        end
    endtask

    // receiver holds off while two sets are offered back to back
    task automatic test_backpressure();
        write_direction(dir_e'($urandom_range(0, 1)));
        hold_left <= LONG_HOLD;
        send_random_frame(FILL_FULL);
        send_random_frame(FILL_CORNERS);
        wait_for_spectrum_drain();
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s", what);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        bin_t                 want;
        logic signed [BW-1:0] got_re;
        logic signed [BW-1:0] got_im;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_re = m_axis_tdata[BW-1:0];
            got_im = m_axis_tdata[2*BW-1:BW];
            if (expected_bins.size() == 0)
            begin
                note_mismatch($sformatf("unexpected bin word: re %0d im %0d last %0b",
                                        got_re, got_im, m_axis_tlast));
            end
            else
            begin
                want = expected_bins.pop_front();
                if (got_re !== want.re || got_im !== want.im || m_axis_tlast !== want.last)
                begin
                    note_mismatch($sformatf(
                        "bin mismatch: expected re %0d im %0d last %0b, got re %0d im %0d last %0b",
                        want.re, want.im, want.last, got_re, got_im, m_axis_tlast));
                end
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int m;
        for (m = 0; m < N; m++)
        begin
            twiddle_at(m, cos_tab[m], sin_tab[m]);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 50;
        test_extremes();
        test_clipping();

        send_idle_pct = 50;
        recv_idle_pct = 9;
        test_random_frames(2);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();

        wait_for_spectrum_drain();
        if (mismatches == 0 && expected_bins.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ddft_pkg.sv
rtl/ddft_ram.sv
rtl/ddft_ctrl.sv
rtl/ddft_dp.sv
rtl/direct_dft_forward_inverse.sv
bench/direct_dft_forward_inverse_test.sv
